/* rtl/signed_rounded_reciprocal_defines.svh */
// Assertion macros for the signed rounded reciprocal block.
// No dependencies; included by the top level only.
`ifndef SIGNED_ROUNDED_RECIPROCAL_DEFINES_SVH
`define SIGNED_ROUNDED_RECIPROCAL_DEFINES_SVH
`ifndef SYNTHESIS
// Check an implication at each clock edge outside reset.
`define SRR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("srr assertion failed");
// Check that a condition never holds outside reset.
`define SRR_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("srr forbidden condition seen");
`else
`define SRR_ASSERT(label, clk, rst, prop)
`define SRR_NEVER(label, clk, rst, expr)
`endif
`endif

/* rtl/srr_pkg.sv */
// Shared types and constants for the signed rounded reciprocal pipeline.
// No dependencies.
package srr_pkg;

  // Default operand width.
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Per-beat control that travels with the data down the pipeline.
  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } srr_ctl_t;

endpackage

/* rtl/signed_rounded_reciprocal.sv */
// Top level of the signed rounded reciprocal: front stage, divider cell chain, back end.
// Depends on srr_pkg, srr_front, srr_cell, srr_back and the defines header.
//
// Returns round((2^W - 1) / |value|) with the sign of value, as a W-bit two's
// complement pattern, W = DATA_WIDTH. A zero operand gives reciprocal 0 with
// divide_by_zero set. The block takes one operand in every clock cycle
// (start while busy is low; busy is high only during reset) and delivers each
// result in order, as a one-cycle beat marked by done. The pipeline is the
// chain of DATA_WIDTH restoring-division cells, one quotient bit per cell,
// plus one magnitude stage and two stages for rounding and sign. The
// receiver cannot stall: a result must be taken in the cycle that done is high.
`include "signed_rounded_reciprocal_defines.svh"
module signed_rounded_reciprocal #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic                         done,
  output logic        [DATA_WIDTH-1:0] reciprocal,
  output logic                         divide_by_zero
);
  import srr_pkg::*;

  localparam int unsigned LATENCY = DATA_WIDTH + 3;

  srr_ctl_t              ctl_c [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] mag_c [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem_c [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] quo_c [0:DATA_WIDTH];
  logic                  accept;

  // Refuse beats only while in reset
  assign busy   = rst;
  assign accept = start && !busy;

  // Magnitude stage
  srr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .value    (value),
    .ctl      (ctl_c[0]),
    .mag      (mag_c[0])
  );

  // Division starts with empty remainder and quotient
  assign rem_c[0] = '0;
  assign quo_c[0] = '0;

  // One cell per quotient bit
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    srr_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_c[i]),
      .mag_in  (mag_c[i]),
      .rem_in  (rem_c[i]),
      .quo_in  (quo_c[i]),
      .ctl_out (ctl_c[i+1]),
      .mag_out (mag_c[i+1]),
      .rem_out (rem_c[i+1]),
      .quo_out (quo_c[i+1])
    );
  end

  // Rounding, sign and result register
  srr_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .ctl_in         (ctl_c[DATA_WIDTH]),
    .mag_in         (mag_c[DATA_WIDTH]),
    .rem_in         (rem_c[DATA_WIDTH]),
    .quo_in         (quo_c[DATA_WIDTH]),
    .done           (done),
    .reciprocal     (reciprocal),
    .divide_by_zero (divide_by_zero)
  );

  // Every result beat traces back to an accepted operand at fixed latency
  `SRR_ASSERT(a_done_latency, clk, rst, done |-> $past(accept, LATENCY))
  // Zero flag follows the operand that produced the beat
  `SRR_ASSERT(a_dbz_match, clk, rst, done |-> (divide_by_zero == ($past(value, LATENCY) == '0)))
  // A flagged beat carries a zero result
  `SRR_NEVER(a_dbz_zero, clk, rst, done && divide_by_zero && (reciprocal != '0))
  // A nonzero operand never yields a zero reciprocal
  `SRR_NEVER(a_nonzero, clk, rst, done && !divide_by_zero && (reciprocal == '0))

endmodule

/* rtl/srr_front.sv */
// Front stage: sign split and magnitude of the operand.
// Depends on srr_pkg.
module srr_front #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] value,
  output srr_pkg::srr_ctl_t     ctl,
  output logic [DATA_WIDTH-1:0] mag
);
  import srr_pkg::*;

  srr_ctl_t              ctl_next;
  logic [DATA_WIDTH-1:0] mag_next;

  // Split sign and take the magnitude; the most negative value maps to 2^(W-1)
  always_comb begin
    ctl_next.valid = in_valid;
    ctl_next.neg   = value[DATA_WIDTH-1];
    ctl_next.zero  = (value == '0);
    mag_next       = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;
  end

  // Register the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl_next.valid;
    end
    ctl.neg  <= ctl_next.neg;
    ctl.zero <= ctl_next.zero;
    mag      <= mag_next;
  end

endmodule

/* rtl/srr_cell.sv */
// One restoring-division cell: produces one quotient bit of all-ones / mag.
// Depends on srr_pkg.
module srr_cell #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srr_pkg::srr_ctl_t     ctl_in,
  input  logic [DATA_WIDTH-1:0] mag_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  output srr_pkg::srr_ctl_t     ctl_out,
  output logic [DATA_WIDTH-1:0] mag_out,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] quo_out
);
  import srr_pkg::*;

  logic [DATA_WIDTH-1:0] trial;
  logic                  take;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] quo_next;

  // Shift in the next dividend bit (always one) and try to subtract.
  // The remainder stays below mag <= 2^(W-1), so the shift never overflows.
  always_comb begin
    trial    = {rem_in[DATA_WIDTH-2:0], 1'b1};
    take     = (trial >= mag_in);
    rem_next = take ? (trial - mag_in) : trial;
    quo_next = {quo_in[DATA_WIDTH-2:0], take};
  end

  // Hand the beat to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.neg  <= ctl_in.neg;
    ctl_out.zero <= ctl_in.zero;
    mag_out      <= mag_in;
    rem_out      <= rem_next;
    quo_out      <= quo_next;
  end

endmodule

/* rtl/srr_back.sv */
// Back end: rounding of the quotient, sign restore and result register.
// Depends on srr_pkg.
module srr_back #(
  parameter int unsigned DATA_WIDTH = srr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srr_pkg::srr_ctl_t     ctl_in,
  input  logic [DATA_WIDTH-1:0] mag_in,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] reciprocal,
  output logic                  divide_by_zero
);
  import srr_pkg::*;

  srr_ctl_t              ctl_r;
  logic [DATA_WIDTH-1:0] quo_r;
  logic                  round_up;
  logic [DATA_WIDTH-1:0] quo_rnd_next;
  logic [DATA_WIDTH-1:0] res_next;

  // Round up when half the magnitude is strictly below the remainder
  always_comb begin
    round_up     = ((mag_in >> 1) < rem_in);
    quo_rnd_next = quo_in + {{(DATA_WIDTH-1){1'b0}}, round_up};
  end

  // Hold the rounded quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.neg  <= ctl_in.neg;
    ctl_r.zero <= ctl_in.zero;
    quo_r      <= quo_rnd_next;
  end

  // Reapply the sign; force zero for a zero operand
  always_comb begin
    if (ctl_r.zero) begin
      res_next = '0;
    end else if (ctl_r.neg) begin
      res_next = ~quo_r + 1'b1;
    end else begin
      res_next = quo_r;
    end
  end

  // Present the result beat for one cycle
  always_ff @(posedge clk) begin
    reciprocal     <= res_next;
    divide_by_zero <= ctl_r.zero;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_r.valid;
    end
  end

endmodule
